@@ rtl/ddo_pkg.sv @@
// Package for the odometry integrator: constants, types and the arctangent table.
`default_nettype none
package ddo_pkg;

	localparam int CORDIC_STEPS = 20;

	localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
	localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

	localparam logic KIND_MOTION = 1'b0;
	localparam logic KIND_RESET  = 1'b1;

	// Velocity selectors for the shared divider.
	localparam logic [1:0] VEL_X    = 2'd0;
	localparam logic [1:0] VEL_Y    = 2'd1;
	localparam logic [1:0] VEL_TURN = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_REDUCE, ST_FOLD, ST_ROTATE, ST_MUL_A, ST_MUL_B, ST_MUL_C,
		ST_UPDATE, ST_DIV, ST_DIV_WAIT, ST_OUTPUT
	} ddo_state_t;

	// Divider sequencing phases.
	typedef enum logic [1:0] {
		DIV_IDLE, DIV_MUL, DIV_RUN
	} div_phase_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic       load;      // capture input item
		logic       clear;     // zero the pose
		logic       ang_sel;   // 0: half-turn angle, 1: travel heading
		logic       reduce;    // compute angle modulo 2*pi (one step)
		logic       fold;      // start reduction of the selected angle
		logic       rot_step;  // one CORDIC iteration
		logic       mul_a;     // first product
		logic       mul_b;     // second product stage
		logic       mul_c;     // finish deltas
		logic       update;    // update pose
		logic       div_start; // start a velocity division
		logic [1:0] div_sel;   // which velocity
		logic       div_store; // store the quotient
	} ddo_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic reduce_done;
		logic rot_done;
		logic straight;
		logic div_done;
	} ddo_stat_t;

	function automatic logic signed [35:0] atan_q30(input logic [4:0] k);
		logic signed [35:0] t;
		unique case (k)
			5'd0:  t = 36'sd843314856;
			5'd1:  t = 36'sd497837829;
			5'd2:  t = 36'sd263043836;
			5'd3:  t = 36'sd133525158;
			5'd4:  t = 36'sd67021686;
			5'd5:  t = 36'sd33543515;
			5'd6:  t = 36'sd16775850;
			5'd7:  t = 36'sd8388437;
			5'd8:  t = 36'sd4194282;
			5'd9:  t = 36'sd2097149;
			5'd10: t = 36'sd1048575;
			5'd11: t = 36'sd524287;
			5'd12: t = 36'sd262143;
			5'd13: t = 36'sd131071;
			5'd14: t = 36'sd65535;
			5'd15: t = 36'sd32767;
			5'd16: t = 36'sd16383;
			5'd17: t = 36'sd8191;
			5'd18: t = 36'sd4095;
			5'd19: t = 36'sd2047;
			5'd20: t = 36'sd1023;
			5'd21: t = 36'sd511;
			5'd22: t = 36'sd255;
			5'd23: t = 36'sd127;
			5'd24: t = 36'sd63;
			5'd25: t = 36'sd31;
			5'd26: t = 36'sd15;
			5'd27: t = 36'sd7;
			5'd28: t = 36'sd3;
			5'd29: t = 36'sd1;
			default: t = 36'sd0;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

@@ rtl/diff_drive_odometry_integrator.sv @@
// Top level of the dead-reckoning odometry integrator.
// Usage: motion transactions enter on the s_axis channel; tuser carries kind
// (0 = motion sample, 1 = reset pose to origin), tdata carries turn_delta,
// signed_radius and elapsed_us. Each motion transaction yields one result on
// m_axis: tdata holds pos_x, pos_y, heading, vel_x, vel_y, vel_turn, and
// tuser holds rate_invalid and rate_saturated. A reset transaction clears the
// pose in the cycle it is accepted and produces no result.
// Processing: the trig work runs one angle reduction for a straight move and
// two for a curve, each stepping down through 2*pi times powers of two, and
// one CORDIC pass of CORDIC_STEPS iterations per angle, one iteration per
// cycle, then the product and pose update steps. Three serial divisions
// follow for the velocities; the velocity divider, one quotient bit per
// cycle, takes the largest share of the time before a result is valid.
// One item is handled at a time; s_axis_tready is high only when idle, in the
// cycle after the result is taken at the earliest.
// When the receiver stalls, the result stays valid and stable until taken.
// After arst_n the pose is zero and the block is idle.
`default_nettype none
module diff_drive_odometry_integrator
	import ddo_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [79:0]  s_axis_tdata,  // turn_delta[23:0], signed_radius[55:24], elapsed_us[79:56]
	input  wire logic         s_axis_tuser,  // kind
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [191:0]      m_axis_tdata,  // pos_x, pos_y, heading, vel_x, vel_y, vel_turn (32 each)
	output logic [1:0]        m_axis_tuser   // rate_invalid[0], rate_saturated[1]
);
	ddo_cmd_t  cmd;
	ddo_stat_t stat;
	logic [31:0] pos_x, pos_y, heading, vel_x, vel_y, vel_turn;
	logic rate_invalid, rate_saturated;

	ddo_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_kind(s_axis_tuser),
		.in_ready(s_axis_tready), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.cmd(cmd), .stat(stat)
	);

	ddo_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_turn(s_axis_tdata[23:0]), .in_radius(s_axis_tdata[55:24]),
		.in_elapsed(s_axis_tdata[79:56]),
		.pos_x(pos_x), .pos_y(pos_y), .heading(heading), .vel_x(vel_x), .vel_y(vel_y),
		.vel_turn(vel_turn), .rate_invalid(rate_invalid), .rate_saturated(rate_saturated)
	);

	assign m_axis_tdata = {vel_turn, vel_y, vel_x, heading, pos_y, pos_x};
	assign m_axis_tuser = {rate_saturated, rate_invalid};
endmodule
`default_nettype wire

@@ rtl/ddo_divider.sv @@
// Serial signed divider for velocities: delta * 1e6 / elapsed, truncated, saturated to 32 bits.
`default_nettype none
module ddo_divider
	import ddo_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [39:0] delta,
	input  wire logic [23:0]        divisor,
	output logic                    busy,
	output logic                    done,
	output logic signed [31:0]      quotient,
	output logic                    saturated
);
	// |delta| < 2^39 and 1e6 < 2^20: dividend magnitude fits 59 bits.
	localparam int NB = 59;

	logic [NB-1:0] num_q;
	logic [NB-1:0] quo_q;
	logic [23:0]   rem_q;
	logic [23:0]   den_q;
	logic          neg_q;
	logic [5:0]    cnt_q;
	div_phase_t    phase_q;
	logic [38:0]   mag_q;
	logic          done_q;

	logic [24:0] trial;
	logic [NB-1:0] qmag;
	logic [NB:0]   qs;

	always_comb begin
		trial = {rem_q, num_q[NB-1]} - {1'b0, den_q};
		qmag  = quo_q;
		qs    = neg_q ? -{1'b0, qmag} : {1'b0, qmag};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= DIV_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				DIV_IDLE: begin
					if (start) begin
						phase_q <= DIV_MUL;
					end
				end
				DIV_MUL: begin
					phase_q <= DIV_RUN;
					cnt_q   <= 6'(NB);
				end
				DIV_RUN: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						phase_q <= DIV_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: phase_q <= DIV_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == DIV_IDLE && start) begin
			neg_q <= delta[39];
			mag_q <= delta[39] ? 39'(-delta) : delta[38:0];
			den_q <= divisor;
		end else if (phase_q == DIV_MUL) begin
			num_q <= NB'(mag_q) * NB'(USEC_PER_SEC);
			quo_q <= '0;
			rem_q <= '0;
		end else if (phase_q == DIV_RUN) begin
			num_q <= {num_q[NB-2:0], 1'b0};
			if (!trial[24]) begin
				rem_q <= trial[23:0];
				quo_q <= {quo_q[NB-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[22:0], num_q[NB-1]};
				quo_q <= {quo_q[NB-2:0], 1'b0};
			end
		end
	end

	logic signed [NB:0] sq;
	assign sq = signed'(qs);

	always_comb begin
		saturated = 1'b0;
		if (sq > (NB+1)'(signed'(32'h7FFFFFFF))) begin
			quotient  = 32'sh7FFFFFFF;
			saturated = 1'b1;
		end else if (sq < -(NB+1)'(64'sh80000000)) begin
			quotient  = 32'sh80000000;
			saturated = 1'b1;
		end else begin
			quotient = sq[31:0];
		end
	end

	assign busy = (phase_q != DIV_IDLE);
	assign done = done_q;
endmodule
`default_nettype wire

@@ rtl/ddo_datapath.sv @@
// Datapath: pose registers, angle reduction, CORDIC, products and velocity division.
`default_nettype none
module ddo_datapath
	import ddo_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  ddo_cmd_t                cmd,
	output ddo_stat_t               stat,
	input  wire logic [23:0]        in_turn,
	input  wire logic [31:0]        in_radius,
	input  wire logic [23:0]        in_elapsed,
	output logic [31:0]             pos_x,
	output logic [31:0]             pos_y,
	output logic [31:0]             heading,
	output logic [31:0]             vel_x,
	output logic [31:0]             vel_y,
	output logic [31:0]             vel_turn,
	output logic                    rate_invalid,
	output logic                    rate_saturated
);
	logic [31:0] acc_x_q, acc_y_q, acc_h_q;
	logic signed [23:0] d_q;
	logic signed [31:0] rad_q;
	logic [23:0] us_q;

	// Angle reduction: |angle| < 2^42, subtract 2pi*2^k from the magnitude.
	logic signed [43:0] ang_q;
	logic               ang_neg_q;
	logic [4:0]         red_k_q;
	logic signed [35:0] z_q;
	logic signed [33:0] x_q, y_q;
	logic               flip_q;
	logic [4:0]         it_q;
	logic signed [33:0] s_q, c_q;
	logic signed [63:0] pa_s1, pb_s1;
	logic signed [33:0] chord_q;
	logic signed [33:0] dx_q, dy_q;
	logic signed [31:0] vx_q, vy_q, vt_q;
	logic               sat_q;

	logic signed [43:0] ang_in;
	logic [43:0]        ang_mag;
	logic [43:0]        sub_val;
	logic signed [35:0] r_mod;
	logic signed [35:0] r_fold;
	logic               flip;
	logic signed [33:0] xs, ys;
	logic signed [33:0] c_fin, s_fin;
	logic               div_busy, div_done, div_sat;
	logic signed [31:0] div_q;
	logic signed [39:0] div_delta;

	always_comb begin
		if (cmd.ang_sel)
			ang_in = ($signed({{12{acc_h_q[31]}}, acc_h_q}) <<< 10)
				+ ($signed({{20{d_q[23]}}, d_q}) <<< 9);
		else
			ang_in = $signed({{20{d_q[23]}}, d_q}) <<< 9;
		ang_mag = ang_q[43] ? 44'(-ang_q) : 44'(ang_q);
		sub_val = 44'(TWO_PI_Q30) << red_k_q;
		// Truncated remainder keeps dividend sign; then the model's adjustments.
		r_mod = ang_neg_q ? -36'(ang_mag) : 36'(ang_mag);
		if (r_mod < 0) r_mod = r_mod + TWO_PI_Q30;
		if (r_mod > PI_Q30) r_mod = r_mod - TWO_PI_Q30;
		flip = 1'b0;
		r_fold = r_mod;
		if (r_mod > HALF_PI_Q30) begin
			r_fold = r_mod - PI_Q30;
			flip = 1'b1;
		end else if (r_mod < -HALF_PI_Q30) begin
			r_fold = r_mod + PI_Q30;
			flip = 1'b1;
		end
		xs = x_q >>> it_q;
		ys = y_q >>> it_q;
		c_fin = flip_q ? -x_q : x_q;
		s_fin = flip_q ? -y_q : y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_h_q <= '0;
		end else if (cmd.clear) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_h_q <= '0;
		end else if (cmd.update) begin
			acc_x_q <= acc_x_q + dx_q[31:0];
			acc_y_q <= acc_y_q + dy_q[31:0];
			acc_h_q <= acc_h_q + 32'(d_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			d_q   <= in_turn;
			rad_q <= in_radius;
			us_q  <= in_elapsed;
			sat_q <= 1'b0;
		end
		if (cmd.fold && !cmd.reduce) begin
			// Start reduction of the selected angle.
			ang_q     <= ang_in;
			ang_neg_q <= ang_in[43];
			red_k_q   <= 5'd11;
		end
		if (cmd.reduce) begin
			if (ang_mag >= sub_val)
				ang_q <= ang_q[43] ? 44'(ang_q + sub_val) : 44'(ang_q - sub_val);
			else
				red_k_q <= red_k_q - 5'd1;
			if (red_k_q == 5'd0 && ang_mag < sub_val) begin
				z_q    <= r_fold;
				flip_q <= flip;
				x_q    <= GAIN_Q30;
				y_q    <= '0;
				it_q   <= '0;
			end
		end
		if (cmd.rot_step) begin
			if (!z_q[35]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_q30(it_q);
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_q30(it_q);
			end
			it_q <= it_q + 5'd1;
		end
		if (cmd.mul_a) begin
			if (cmd.ang_sel) begin
				s_q <= s_fin;
				c_q <= c_fin;
			end else begin
				pa_s1 <= 64'(rad_q * s_fin);
			end
		end
		if (cmd.mul_b) begin
			if (!cmd.ang_sel) begin
				chord_q <= 34'((pa_s1 + 64'sd268435456) >>> 29);
			end else if (d_q == 24'sd0) begin
				pa_s1 <= 64'(rad_q * c_q);
				pb_s1 <= 64'(rad_q * s_q);
			end else begin
				pa_s1 <= 64'(chord_q * c_q);
				pb_s1 <= 64'(chord_q * s_q);
			end
		end
		if (cmd.mul_c) begin
			dx_q <= 34'((pa_s1 + 64'sd536870912) >>> 30);
			dy_q <= 34'((pb_s1 + 64'sd536870912) >>> 30);
		end
		if (div_done) begin
			unique case (cmd.div_sel)
				VEL_X: vx_q <= div_q;
				VEL_Y: vy_q <= div_q;
				default: vt_q <= div_q;
			endcase
			sat_q <= sat_q | div_sat;
		end
	end

	always_comb begin
		unique case (cmd.div_sel)
			VEL_X: div_delta = 40'(dx_q);
			VEL_Y: div_delta = 40'(dy_q);
			default: div_delta = 40'(d_q);
		endcase
	end

	ddo_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .delta(div_delta),
		.divisor(us_q), .busy(div_busy), .done(div_done), .quotient(div_q),
		.saturated(div_sat)
	);

	assign stat.reduce_done = (red_k_q == 5'd0) && (ang_mag < sub_val);
	assign stat.rot_done    = (it_q == 5'(CORDIC_STEPS - 1));
	assign stat.straight    = (d_q == 24'sd0);
	assign stat.div_done    = div_done && !div_busy;

	assign pos_x          = acc_x_q;
	assign pos_y          = acc_y_q;
	assign heading        = acc_h_q;
	assign rate_invalid   = (us_q == 24'd0);
	assign vel_x          = rate_invalid ? 32'd0 : vx_q;
	assign vel_y          = rate_invalid ? 32'd0 : vy_q;
	assign vel_turn       = rate_invalid ? 32'd0 : vt_q;
	assign rate_saturated = rate_invalid ? 1'b0 : sat_q;
endmodule
`default_nettype wire

@@ rtl/ddo_ctrl.sv @@
// Controller state machine that sequences one motion transaction through the datapath.
`default_nettype none
module ddo_ctrl
	import ddo_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire logic  in_kind,
	output logic       in_ready,
	output logic       out_valid,
	input  wire logic  out_ready,
	output ddo_cmd_t   cmd,
	input  ddo_stat_t  stat
);
	ddo_state_t state_q, state_d;
	logic       sel_q, sel_d;   // 1 while working on the travel heading
	logic [1:0] dsel_q, dsel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= 1'b0;
			dsel_q  <= VEL_X;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			dsel_q  <= dsel_d;
		end
	end

	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		dsel_d  = dsel_q;
		cmd     = '0;
		cmd.ang_sel = sel_q;
		cmd.div_sel = dsel_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_kind == KIND_RESET) begin
						cmd.clear = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d  = ST_FOLD;
						sel_d    = 1'b0;
					end
				end
			end
			ST_FOLD: begin
				// A straight move needs only the heading angle.
				if (!sel_q && stat.straight) begin
					sel_d = 1'b1;
				end else begin
					cmd.fold = 1'b1;
					state_d  = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				cmd.reduce = 1'b1;
				if (stat.reduce_done) state_d = ST_ROTATE;
			end
			ST_ROTATE: begin
				cmd.rot_step = 1'b1;
				if (stat.rot_done) state_d = ST_MUL_A;
			end
			ST_MUL_A: begin
				cmd.mul_a = 1'b1;
				state_d   = ST_MUL_B;
			end
			ST_MUL_B: begin
				cmd.mul_b = 1'b1;
				if (!sel_q) begin
					sel_d   = 1'b1;
					state_d = ST_FOLD;
				end else begin
					state_d = ST_MUL_C;
				end
			end
			ST_MUL_C: begin
				cmd.mul_c = 1'b1;
				state_d   = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				dsel_d     = VEL_X;
				state_d    = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (stat.div_done) begin
					if (dsel_q == VEL_TURN) begin
						state_d = ST_OUTPUT;
					end else begin
						dsel_d  = dsel_q + 2'd1;
						state_d = ST_DIV;
					end
				end
			end
			ST_OUTPUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_out_only_in_output: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_OUTPUT) else $error("result shown outside output");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("input taken while result pending");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule
`default_nettype wire

@@ bench/diff_drive_odometry_integrator_tb.sv @@
// Self-checking testbench for the dead-reckoning odometry integrator.
`timescale 1ns / 100ps
`default_nettype none
module diff_drive_odometry_integrator_tb;
	import ddo_pkg::*;

	// One motion or reset request as it travels on the input stream.
	typedef struct {
		logic        kind;
		logic [23:0] turn_delta;
		logic [31:0] signed_radius;
		logic [23:0] elapsed_us;
	} motion_t;

	// One pose report as it leaves the block.
	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] heading;
		logic [31:0] vel_x;
		logic [31:0] vel_y;
		logic [31:0] vel_turn;
		logic        rate_invalid;
		logic        rate_saturated;
	} pose_t;

	localparam int ATAN_TABLE_STEPS = 32;
	localparam longint SIM_LIMIT_NS = 64'd400_000_000;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [79:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [191:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;

	diff_drive_odometry_integrator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	motion_t pending_motion[$];
	pose_t expected_poses[$];

	// The predictor keeps its own copy of the accumulated pose.
	logic [31:0] pose_x;
	logic [31:0] pose_y;
	logic [31:0] pose_heading;

	int error_count = 0;
	int motions_sent = 0;
	int resets_sent = 0;
	int poses_checked = 0;
	int saturated_seen = 0;
	int invalid_seen = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	bit hold_sender = 0;
	bit stimulus_done = 0;
	bit in_taken = 0;

	// Arctangent constants for the rotation, Q30 radians.
	function automatic longint atan_entry(input int k);
		longint atan_tab[ATAN_TABLE_STEPS] = '{
			843314856, 497837829, 263043836, 133525158,
			67021686, 33543515, 16775850, 8388437,
			4194282, 2097149, 1048575, 524287,
			262143, 131071, 65535, 32767,
			16383, 8191, 4095, 2047,
			1023, 511, 255, 127,
			63, 31, 15, 7, 3, 1, 0, 0};
		return atan_tab[k % ATAN_TABLE_STEPS];
	endfunction

	// Scale by 2^-n with the half-up rounding the datapath uses.
	function automatic longint scale_round(input longint v, input int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	// Sine and cosine of a Q30 angle: reduce to (-pi, pi], fold to the right
	// half plane, then run the rotation-mode iterations from the gain.
	task automatic trig_q30(input longint ang, output longint sin_v, output longint cos_v);
		longint r;
		longint xr;
		longint yr;
		longint zr;
		longint xs;
		longint ys;
		bit flip;
		r = ang % longint'(TWO_PI_Q30);
		xr = longint'(GAIN_Q30);
		yr = 0;
		flip = 0;
		if (r < 0) r += longint'(TWO_PI_Q30);
		if (r > longint'(PI_Q30)) r -= longint'(TWO_PI_Q30);
		if (r > longint'(HALF_PI_Q30)) begin
			r -= longint'(PI_Q30);
			flip = 1;
		end else if (r < -longint'(HALF_PI_Q30)) begin
			r += longint'(PI_Q30);
			flip = 1;
		end
		zr = r;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = xr >>> (i % 32);
			ys = yr >>> (i % 32);
			if (zr >= 0) begin
				xr -= ys;
				yr += xs;
				zr -= atan_entry(i);
			end else begin
				xr += ys;
				yr -= xs;
				zr += atan_entry(i);
			end
		end
		cos_v = flip ? -xr : xr;
		sin_v = flip ? -yr : yr;
	endtask

	// Velocity from a delta, clipped to the 32-bit signed range.
	function automatic logic [31:0] clipped_rate(input longint delta, input longint us,
			inout bit sat);
		longint v;
		v = (delta * 1000000) / us;
		if (v > 64'sd2147483647) begin
			sat = 1;
			v = 64'sd2147483647;
		end else if (v < -64'sd2147483648) begin
			sat = 1;
			v = -64'sd2147483648;
		end
		return v[31:0];
	endfunction

	// Advance the pose for one accepted motion and queue its report; a reset only clears the pose.
	task automatic integrate_motion(input motion_t m);
		longint d;
		longint rad;
		longint us;
		longint head;
		longint dx;
		longint dy;
		longint s;
		longint c;
		longint hs;
		longint hc;
		longint chord;
		bit sat;
		pose_t p;
		d = longint'($signed(m.turn_delta));
		rad = longint'($signed(m.signed_radius));
		us = longint'(m.elapsed_us);
		head = longint'($signed(pose_heading));
		sat = 0;
		if (m.kind == KIND_RESET) begin
			pose_x = '0;
			pose_y = '0;
			pose_heading = '0;
			return;
		end
		if (d == 0) begin
			trig_q30(head * 1024, s, c);
			dx = scale_round(rad * c, 30);
			dy = scale_round(rad * s, 30);
		end else begin
			trig_q30(d * 512, hs, hc);
			chord = scale_round(rad * hs, 29);
			trig_q30(head * 1024 + d * 512, s, c);
			dx = scale_round(chord * c, 30);
			dy = scale_round(chord * s, 30);
		end
		pose_x = pose_x + dx[31:0];
		pose_y = pose_y + dy[31:0];
		pose_heading = pose_heading + d[31:0];
		p.pos_x = pose_x;
		p.pos_y = pose_y;
		p.heading = pose_heading;
		p.rate_invalid = (us == 0);
		if (us == 0) begin
			p.vel_x = '0;
			p.vel_y = '0;
			p.vel_turn = '0;
		end else begin
			p.vel_x = clipped_rate(dx, us, sat);
			p.vel_y = clipped_rate(dy, us, sat);
			p.vel_turn = clipped_rate(d, us, sat);
		end
		p.rate_saturated = sat;
		expected_poses.push_back(p);
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(SIM_LIMIT_NS);
		$display("timeout at %0t", $time);
		$display("DONE: errors detected");
		$finish;
	end

	// Input acceptance is recorded at the rising edge where it happens.
	always @(posedge clk)
		in_taken <= arst_n && s_axis_tvalid && s_axis_tready;

	// Driver: presents the head of the queue, updates the predictor on acceptance.
	always @(negedge clk or negedge arst_n) begin
		motion_t m;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
		end else begin
			if (in_taken) begin
				m = pending_motion.pop_front();
				integrate_motion(m);
				if (m.kind == KIND_RESET)
					resets_sent++;
				else
					motions_sent++;
			end
			if (in_taken || !s_axis_tvalid) begin
				if (pending_motion.size() > 0 && !hold_sender
						&& $urandom_range(99, 0) >= sender_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= pending_motion[0].kind;
					s_axis_tdata <= {pending_motion[0].elapsed_us,
						pending_motion[0].signed_radius, pending_motion[0].turn_delta};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(99, 0) >= receiver_stall_pct);
	end

	// Monitor: compares every accepted report with the oldest expectation.
	always @(posedge clk) begin
		pose_t got;
		pose_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.pos_x = m_axis_tdata[31:0];
			got.pos_y = m_axis_tdata[63:32];
			got.heading = m_axis_tdata[95:64];
			got.vel_x = m_axis_tdata[127:96];
			got.vel_y = m_axis_tdata[159:128];
			got.vel_turn = m_axis_tdata[191:160];
			got.rate_invalid = m_axis_tuser[0];
			got.rate_saturated = m_axis_tuser[1];
			if (expected_poses.size() == 0) begin
				$display("%0t: unexpected pose transaction x=%h y=%h h=%h",
					$time, got.pos_x, got.pos_y, got.heading);
				error_count++;
			end else begin
				want = expected_poses.pop_front();
				poses_checked++;
				if (want.rate_saturated) saturated_seen++;
				if (want.rate_invalid) invalid_seen++;
				if (got !== want) begin
					error_count++;
					$display("%0t: pose mismatch", $time);
					$display("  expected x=%h y=%h h=%h vx=%h vy=%h vt=%h inv=%b sat=%b",
						want.pos_x, want.pos_y, want.heading, want.vel_x, want.vel_y,
						want.vel_turn, want.rate_invalid, want.rate_saturated);
					$display("  actual   x=%h y=%h h=%h vx=%h vy=%h vt=%h inv=%b sat=%b",
						got.pos_x, got.pos_y, got.heading, got.vel_x, got.vel_y,
						got.vel_turn, got.rate_invalid, got.rate_saturated);
				end
			end
		end
	end

	function automatic motion_t make_motion(input logic kind, input logic [23:0] d,
			input logic [31:0] r, input logic [23:0] us);
		motion_t m;
		m.kind = kind;
		m.turn_delta = d;
		m.signed_radius = r;
		m.elapsed_us = us;
		return m;
	endfunction

	// Mostly realistic motion at 50 Hz with small turns and radii, mixed
	// with full-range noise, zero time steps and occasional pose resets.
	function automatic motion_t random_motion();
		int pick;
		logic [23:0] d;
		logic [31:0] r;
		logic [23:0] us;
		pick = $urandom_range(99, 0);
		d = $urandom;
		r = $urandom;
		us = $urandom;
		if (pick < 4)
			return make_motion(KIND_RESET, d, r, us);
		if (pick < 55) begin
			d = $urandom_range(1, 0) ? 24'(-$urandom_range(200000, 0))
				: 24'($urandom_range(200000, 0));
			r = $urandom_range(1, 0) ? 32'(-$urandom_range(100000, 0))
				: 32'($urandom_range(100000, 0));
			us = $urandom_range(21000, 19000);
		end else if (pick < 70) begin
			d = '0;
			r = $urandom_range(1, 0) ? 32'(-$urandom_range(5000, 0))
				: 32'($urandom_range(5000, 0));
			us = $urandom_range(30000, 1);
		end else if (pick < 78) begin
			us = $urandom_range(20, 0);
		end else if (pick < 83) begin
			us = '0;
		end
		return make_motion(KIND_MOTION, d, r, us);
	endfunction

	task automatic run_phase(input int n, input int idle_pct, input int stall_pct);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		for (int i = 0; i < n; i++)
			pending_motion.push_back(random_motion());
		while (pending_motion.size() > 0) @(posedge clk);
	endtask

	initial begin
		int wait_cycles;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = 0;
		m_axis_tready = 0;
		pose_x = '0;
		pose_y = '0;
		pose_heading = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: field extremes, straight and curved moves, quadrant
		// folding, heading and position wrap, zero time, and velocity clipping.
		pending_motion.push_back(make_motion(KIND_MOTION, 24'd0, 32'd10000, 24'd20000));
		pending_motion.push_back(make_motion(KIND_MOTION, 24'd0, 32'h8000_0000, 24'd1));
		pending_motion.push_back(make_motion(KIND_MOTION, 24'd0, 32'h7FFF_FFFF, 24'hFFFFFF));
		pending_motion.push_back(make_motion(KIND_MOTION, 24'h7FFFFF, 32'h7FFF_FFFF, 24'd1));
		pending_motion.push_back(make_motion(KIND_MOTION, 24'h800000, 32'h8000_0000, 24'd0));
		pending_motion.push_back(make_motion(KIND_MOTION, 24'd1647099, 32'd5000, 24'd20000));
		pending_motion.push_back(make_motion(KIND_MOTION, 24'h800000, 32'd123456, 24'd20000));
		pending_motion.push_back(make_motion(KIND_MOTION, 24'd0, 32'hFFFF_FFFF, 24'd0));
		pending_motion.push_back(make_motion(KIND_RESET, 24'hFFFFFF, 32'hFFFF_FFFF,
			24'hFFFFFF));
		pending_motion.push_back(make_motion(KIND_MOTION, 24'd1, 32'd1, 24'd1));
		pending_motion.push_back(make_motion(KIND_MOTION, 24'hFFFFFF, 32'hFFFF_FFFF, 24'd1));
		pending_motion.push_back(make_motion(KIND_MOTION, 24'd0, 32'd0, 24'd1));
		pending_motion.push_back(make_motion(KIND_MOTION, 24'h555555, 32'h5555_5555,
			24'h555555));
		pending_motion.push_back(make_motion(KIND_MOTION, 24'hAAAAAA, 32'hAAAA_AAAA,
			24'hAAAAAA));
		// Drive heading across its wrap with repeated maximal turns.
		for (int i = 0; i < 6; i++)
			pending_motion.push_back(make_motion(KIND_MOTION, 24'h7FFFFF, 32'd1000, 24'd20000));
		while (pending_motion.size() > 0) @(posedge clk);

		// Pause the sender until every report has come back.
		hold_sender = 1;
		while (expected_poses.size() > 0) @(posedge clk);
		hold_sender = 0;

		run_phase(170, 0, 0);
		run_phase(160, 62, 0);
		run_phase(160, 0, 62);
		run_phase(140, 13, 13);

		wait_cycles = 0;
		while (expected_poses.size() > 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (300) @(posedge clk);
		if (expected_poses.size() > 0) begin
			$display("%0t: %0d expected pose transactions never arrived",
				$time, expected_poses.size());
			error_count++;
		end

		$display("Covered %0d motion and %0d reset transactions, %0d poses checked,",
			motions_sent, resets_sent, poses_checked);
		$display("with %0d zero-time and %0d clipped-velocity reports.",
			invalid_seen, saturated_seen);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire
